// ===== rtl/mi4_pkg.sv =====
// Shared types, widths and cofactor tables for the 4x4 matrix inverse block.
package mi4_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned QueueDepthDefault = 2;

  localparam int unsigned ElemW = 32;
  localparam int unsigned MinorW = 66;   // 2x2 minor, 65 bits plus margin
  localparam int unsigned AdjW = 100;    // adjugate entry, 99 bits plus margin
  localparam int unsigned AccW = 136;    // determinant, 133 bits plus margin
  localparam int unsigned OperW = 128;   // wide operand, four 32-bit limbs

  localparam int unsigned NumMinors = 18;
  localparam int unsigned NumElems = 16;

  typedef logic [NumElems-1:0][ElemW-1:0] mat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LDA,
    ST_LDB,
    ST_MUL,
    ST_DSET,
    ST_DIV,
    ST_EMIT
  } back_state_e;

  typedef enum logic [1:0] {
    PH_MINOR,
    PH_ADJ,
    PH_DET
  } phase_e;

  // minor k = m[a]*m[b] - m[c]*m[d]
  localparam logic [3:0] MINOR_TAB [NumMinors][4] = '{
    '{4'd10, 4'd15, 4'd11, 4'd14}, '{4'd9, 4'd15, 4'd11, 4'd13},
    '{4'd9, 4'd14, 4'd10, 4'd13},  '{4'd8, 4'd15, 4'd11, 4'd12},
    '{4'd8, 4'd14, 4'd10, 4'd12},  '{4'd8, 4'd13, 4'd9, 4'd12},
    '{4'd6, 4'd15, 4'd7, 4'd14},   '{4'd5, 4'd15, 4'd7, 4'd13},
    '{4'd5, 4'd14, 4'd6, 4'd13},   '{4'd6, 4'd11, 4'd7, 4'd10},
    '{4'd5, 4'd11, 4'd7, 4'd9},    '{4'd5, 4'd10, 4'd6, 4'd9},
    '{4'd4, 4'd15, 4'd7, 4'd12},   '{4'd4, 4'd14, 4'd6, 4'd12},
    '{4'd4, 4'd11, 4'd7, 4'd8},    '{4'd4, 4'd10, 4'd6, 4'd8},
    '{4'd4, 4'd13, 4'd5, 4'd12},   '{4'd4, 4'd9, 4'd5, 4'd8}
  };

  // adjugate i = +/- (m[e0]*M[k0] - m[e1]*M[k1] + m[e2]*M[k2]); first entry 1 = negate
  localparam logic [4:0] ADJ_TAB [NumElems][7] = '{
    '{5'd0, 5'd5, 5'd0, 5'd6, 5'd1, 5'd7, 5'd2},
    '{5'd1, 5'd1, 5'd0, 5'd2, 5'd1, 5'd3, 5'd2},
    '{5'd0, 5'd1, 5'd6, 5'd2, 5'd7, 5'd3, 5'd8},
    '{5'd1, 5'd1, 5'd9, 5'd2, 5'd10, 5'd3, 5'd11},
    '{5'd1, 5'd4, 5'd0, 5'd6, 5'd3, 5'd7, 5'd4},
    '{5'd0, 5'd0, 5'd0, 5'd2, 5'd3, 5'd3, 5'd4},
    '{5'd1, 5'd0, 5'd6, 5'd2, 5'd12, 5'd3, 5'd13},
    '{5'd0, 5'd0, 5'd9, 5'd2, 5'd14, 5'd3, 5'd15},
    '{5'd0, 5'd4, 5'd1, 5'd5, 5'd3, 5'd7, 5'd5},
    '{5'd1, 5'd0, 5'd1, 5'd1, 5'd3, 5'd3, 5'd5},
    '{5'd0, 5'd0, 5'd7, 5'd1, 5'd12, 5'd3, 5'd16},
    '{5'd1, 5'd0, 5'd10, 5'd1, 5'd14, 5'd3, 5'd17},
    '{5'd1, 5'd4, 5'd2, 5'd5, 5'd4, 5'd6, 5'd5},
    '{5'd0, 5'd0, 5'd2, 5'd1, 5'd4, 5'd2, 5'd5},
    '{5'd1, 5'd0, 5'd8, 5'd1, 5'd13, 5'd2, 5'd16},
    '{5'd0, 5'd0, 5'd11, 5'd1, 5'd15, 5'd2, 5'd17}
  };

endpackage

// ===== rtl/matrix_inverse_4x4_top.sv =====
// Top level of the 4x4 fixed-point matrix inverse.
// Input channel (in_valid_i/in_ready_o): one matrix element per transfer, with
// its row-major position; elements land in a 16-entry store cleared at reset.
// A transfer to position 15 snapshots the store and queues an inversion job.
// Output channel (out_valid_o/out_ready_i): sixteen results per job in position
// order, the sixteenth flagged by last_result_o; singular_o marks a zero
// determinant (all values zero), saturated_o marks a clipped value.
// Each of the 88 products of minors, adjugate and determinant runs on the one
// shared 33x33 multiplier (two operand loads, four limbs); each result then
// passes through the restoring divider (setup, 33 quotient bits, emit). The
// engine works on one job at a time; element loads overlap with a running job.
// in_ready_o drops only while the job queue is full.
// If the receiver stalls, the result register holds and the engine waits.
// Reset clears the store, the queue and any job in progress.
module matrix_inverse_4x4_top #(
  parameter int unsigned FRAC_BITS   = mi4_pkg::FracBitsDefault,
  parameter int unsigned QUEUE_DEPTH = mi4_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         element_position_i,
  input  logic signed [31:0] element_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         result_position_o,
  output logic signed [31:0] result_value_o,
  output logic               singular_o,
  output logic               saturated_o,
  output logic               last_result_o
);

  logic          q_full, push, pop, job_valid;
  mi4_pkg::mat_t push_data, job;

  mi4_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .element_position_i (element_position_i),
    .element_value_i    (element_value_i),
    .q_full_i           (q_full),
    .push_o             (push),
    .push_data_o        (push_data)
  );

  mi4_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (job_valid),
    .head_o      (job)
  );

  mi4_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_valid_i       (job_valid),
    .job_i             (job),
    .job_pop_o         (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .result_position_o (result_position_o),
    .result_value_o    (result_value_o),
    .singular_o        (singular_o),
    .saturated_o       (saturated_o),
    .last_result_o     (last_result_o)
  );

endmodule

// ===== rtl/mi4_front.sv =====
// Front end: element store and job launch on a write to the last position.
module mi4_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [3:0]                element_position_i,
  input  logic signed [31:0]        element_value_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output mi4_pkg::mat_t             push_data_o
);

  logic [mi4_pkg::NumElems-1:0][mi4_pkg::ElemW-1:0] store_q, store_d;
  logic                                             xfer;

  assign in_ready_o = ~q_full_i;
  assign xfer       = in_valid_i & in_ready_o;

  always_comb begin
    store_d = store_q;
    if (xfer) begin
      store_d[element_position_i] = element_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
    end else begin
      store_q <= store_d;
    end
  end

  // snapshot includes the element written in this transfer
  assign push_o      = xfer & (element_position_i == 4'd15);
  assign push_data_o = store_d;

endmodule

// ===== rtl/mi4_queue.sv =====
// Short job queue between the front end and the inversion engine.
module mi4_queue #(
  parameter int unsigned DEPTH = mi4_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mi4_pkg::mat_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mi4_pkg::mat_t head_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  mi4_pkg::mat_t   mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    if (p == PtrW'(DEPTH - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/mi4_back.sv =====
// Inversion engine: shared 33x33 multiply-accumulate, restoring divider, result register.
module mi4_back #(
  parameter int unsigned FRAC_BITS = mi4_pkg::FracBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  mi4_pkg::mat_t      job_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         result_position_o,
  output logic signed [31:0] result_value_o,
  output logic               singular_o,
  output logic               saturated_o,
  output logic               last_result_o
);

  localparam int unsigned AccW  = mi4_pkg::AccW;
  localparam int unsigned AdjW  = mi4_pkg::AdjW;
  localparam int unsigned MinW  = mi4_pkg::MinorW;
  localparam int unsigned OperW = mi4_pkg::OperW;
  localparam int unsigned DivW  = AccW + 33 + 2 * FRAC_BITS;
  localparam logic [32:0] PosLim = 33'h0_7FFF_FFFF;
  localparam logic [32:0] NegLim = 33'h0_8000_0000;

  mi4_pkg::back_state_e state_q, state_d;
  mi4_pkg::phase_e      phase_q;
  logic [4:0]           grp_q;
  logic [1:0]           term_q, limb_q;
  logic [3:0]           res_q;
  logic [5:0]           it_q;

  logic signed [31:0]   a_q;
  logic [OperW-1:0]     b_q;
  logic [AccW-1:0]      acc_q, acc_d;
  logic [MinW-1:0]      mn_q  [mi4_pkg::NumMinors];
  logic [AdjW-1:0]      adj_q [mi4_pkg::NumElems];
  logic [AccW-1:0]      det_q;
  logic [DivW-1:0]      rem_q, ds_q;
  logic [32:0]          quo_q;
  logic                 neg_q, presat_q;

  logic                 out_valid_q, out_sing_q, out_sat_q, out_last_q;
  logic [3:0]           out_pos_q;
  logic [31:0]          out_val_q;

  // operand decode
  logic [3:0]           a_idx, e_idx;
  logic [4:0]           m_idx;
  logic [3:0]           j_idx;
  logic [1:0]           b_src;   // 0 element, 1 minor, 2 adjugate
  logic                 sub, last_term, grp_last;
  logic [2:0]           at_a, at_b;

  always_comb begin
    at_a      = {term_q, 1'b1};
    at_b      = {term_q, 1'b0} + 3'd2;
    a_idx     = 4'(term_q);
    e_idx     = '0;
    m_idx     = '0;
    j_idx     = {term_q, 2'b00};
    b_src     = 2'd2;
    sub       = 1'b0;
    last_term = (term_q == 2'd3);
    grp_last  = 1'b1;
    case (phase_q)
      mi4_pkg::PH_MINOR: begin
        a_idx     = term_q[0] ? mi4_pkg::MINOR_TAB[grp_q][2] : mi4_pkg::MINOR_TAB[grp_q][0];
        e_idx     = term_q[0] ? mi4_pkg::MINOR_TAB[grp_q][3] : mi4_pkg::MINOR_TAB[grp_q][1];
        b_src     = 2'd0;
        sub       = term_q[0];
        last_term = (term_q == 2'd1);
        grp_last  = (grp_q == 5'd17);
      end
      mi4_pkg::PH_ADJ: begin
        a_idx     = mi4_pkg::ADJ_TAB[grp_q[3:0]][at_a][3:0];
        m_idx     = mi4_pkg::ADJ_TAB[grp_q[3:0]][at_b];
        b_src     = 2'd1;
        // sign of the whole entry folds into each term
        sub       = (term_q == 2'd1) ^ mi4_pkg::ADJ_TAB[grp_q[3:0]][0][0];
        last_term = (term_q == 2'd2);
        grp_last  = (grp_q == 5'd15);
      end
      default: begin
      end
    endcase
  end

  logic [OperW-1:0] b_sel;
  logic [31:0]      e_sel;
  logic [MinW-1:0]  m_sel;
  logic [AdjW-1:0]  j_sel;

  always_comb begin
    e_sel = job_i[e_idx];
    m_sel = mn_q[m_idx];
    j_sel = adj_q[j_idx];
    case (b_src)
      2'd0:    b_sel = {{(OperW-32){e_sel[31]}}, e_sel};
      2'd1:    b_sel = {{(OperW-MinW){m_sel[MinW-1]}}, m_sel};
      default: b_sel = {{(OperW-AdjW){j_sel[AdjW-1]}}, j_sel};
    endcase
  end

  // one limb per cycle; top limb is signed, lower ones unsigned
  logic signed [32:0] limb;
  logic signed [32:0] a_ext;
  logic signed [65:0] prod;
  logic [AccW-1:0]    prod_sh, acc_base;

  always_comb begin
    limb     = (limb_q == 2'd3) ? {b_q[OperW-1], b_q[OperW-1 -: 32]}
                                : {1'b0, b_q[{limb_q, 5'b0} +: 32]};
    a_ext    = {a_q[31], a_q};
    prod     = a_ext * limb;
    prod_sh  = AccW'(prod) << {limb_q, 5'b0};
    acc_base = ((term_q == 2'd0) && (limb_q == 2'd0)) ? '0 : acc_q;
    acc_d    = sub ? (acc_base - prod_sh) : (acc_base + prod_sh);
  end

  // divider setup
  logic            det_zero, dneg, aneg;
  logic [AccW-1:0] dmag;
  logic [AdjW-1:0] adj_cur, amag;
  logic [DivW-1:0] num, den_top;
  logic            ge;

  always_comb begin
    det_zero = (det_q == '0);
    dneg     = det_q[AccW-1];
    dmag     = dneg ? (~det_q + AccW'(1)) : det_q;
    adj_cur  = adj_q[res_q];
    aneg     = adj_cur[AdjW-1];
    amag     = aneg ? (~adj_cur + AdjW'(1)) : adj_cur;
    num      = DivW'(amag) << (2 * FRAC_BITS);
    den_top  = DivW'(dmag) << 33;
    ge       = (rem_q >= ds_q);
  end

  // result formatting
  logic        over, e_sat;
  logic [31:0] e_val;

  always_comb begin
    over  = neg_q ? (quo_q > NegLim) : (quo_q > PosLim);
    e_sat = 1'b0;
    e_val = '0;
    if (!det_zero) begin
      e_sat = presat_q | over;
      if (e_sat) begin
        e_val = neg_q ? NegLim[31:0] : PosLim[31:0];
      end else begin
        e_val = neg_q ? (~quo_q[31:0] + 32'd1) : quo_q[31:0];
      end
    end
  end

  logic out_free, out_load;
  assign out_free = ~out_valid_q | out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mi4_pkg::ST_IDLE: if (job_valid_i) state_d = mi4_pkg::ST_LDA;
      mi4_pkg::ST_LDA:  state_d = mi4_pkg::ST_LDB;
      mi4_pkg::ST_LDB:  state_d = mi4_pkg::ST_MUL;
      mi4_pkg::ST_MUL: begin
        if (limb_q == 2'd3) begin
          if (last_term && grp_last && (phase_q == mi4_pkg::PH_DET)) begin
            state_d = mi4_pkg::ST_DSET;
          end else begin
            state_d = mi4_pkg::ST_LDA;
          end
        end
      end
      mi4_pkg::ST_DSET: state_d = det_zero ? mi4_pkg::ST_EMIT : mi4_pkg::ST_DIV;
      mi4_pkg::ST_DIV:  if (it_q == 6'd32) state_d = mi4_pkg::ST_EMIT;
      mi4_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = (res_q == 4'd15) ? mi4_pkg::ST_IDLE : mi4_pkg::ST_DSET;
        end
      end
      default: state_d = mi4_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    out_load  = 1'b0;
    job_pop_o = 1'b0;
    case (state_q)
      mi4_pkg::ST_EMIT: begin
        out_load  = out_free;
        job_pop_o = out_free && (res_q == 4'd15);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mi4_pkg::ST_IDLE;
      phase_q     <= mi4_pkg::PH_MINOR;
      grp_q       <= '0;
      term_q      <= '0;
      limb_q      <= '0;
      res_q       <= '0;
      it_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        mi4_pkg::ST_IDLE: begin
          phase_q <= mi4_pkg::PH_MINOR;
          grp_q   <= '0;
          term_q  <= '0;
          limb_q  <= '0;
          res_q   <= '0;
        end
        mi4_pkg::ST_MUL: begin
          limb_q <= limb_q + 2'd1;
          if (limb_q == 2'd3) begin
            if (last_term) begin
              term_q <= '0;
              if (grp_last) begin
                grp_q <= '0;
                if (phase_q == mi4_pkg::PH_MINOR) begin
                  phase_q <= mi4_pkg::PH_ADJ;
                end else begin
                  phase_q <= mi4_pkg::PH_DET;
                end
              end else begin
                grp_q <= grp_q + 5'd1;
              end
            end else begin
              term_q <= term_q + 2'd1;
            end
          end
        end
        mi4_pkg::ST_DSET: it_q <= '0;
        mi4_pkg::ST_DIV:  it_q <= it_q + 6'd1;
        mi4_pkg::ST_EMIT: if (out_free) res_q <= res_q + 4'd1;
        default: begin
        end
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      mi4_pkg::ST_LDA: a_q <= job_i[a_idx];
      mi4_pkg::ST_LDB: b_q <= b_sel;
      mi4_pkg::ST_MUL: begin
        acc_q <= acc_d;
        if ((limb_q == 2'd3) && last_term) begin
          case (phase_q)
            mi4_pkg::PH_MINOR: mn_q[grp_q] <= acc_d[MinW-1:0];
            mi4_pkg::PH_ADJ:   adj_q[grp_q[3:0]] <= acc_d[AdjW-1:0];
            default:           det_q <= acc_d;
          endcase
        end
      end
      mi4_pkg::ST_DSET: begin
        rem_q    <= num;
        ds_q     <= DivW'(dmag) << 32;
        quo_q    <= '0;
        neg_q    <= aneg ^ dneg;
        presat_q <= (num >= den_top);
      end
      mi4_pkg::ST_DIV: begin
        rem_q <= ge ? (rem_q - ds_q) : rem_q;
        ds_q  <= ds_q >> 1;
        quo_q <= {quo_q[31:0], ge};
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_pos_q  <= res_q;
      out_val_q  <= e_val;
      out_sing_q <= det_zero;
      out_sat_q  <= e_sat;
      out_last_q <= (res_q == 4'd15);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_position_o = out_pos_q;
  assign result_value_o    = out_val_q;
  assign singular_o        = out_sing_q;
  assign saturated_o       = out_sat_q;
  assign last_result_o     = out_last_q;

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mi4_pkg::ST_DIV) |-> (it_q <= 6'd32))
    else $error("divider ran past its last quotient bit");

  a_pop_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> job_valid_i)
    else $error("job released with none queued");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (res_q == 4'd15)) |=> (out_valid_q && out_last_q))
    else $error("sixteenth result not marked last");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_sing_q) |-> ((out_val_q == '0) && !out_sat_q))
    else $error("singular result carries a value");

endmodule

// ===== dv/matrix_inverse_4x4_top_tb.sv =====
// Self-checking testbench for the 4x4 fixed-point matrix inverse block.
`timescale 1ns / 1ps

module matrix_inverse_4x4_top_tb;

  localparam int unsigned FracBits = mi4_pkg::FracBitsDefault;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned RxHoldCycles = 3000;
  localparam int unsigned IdlePct = 29;
  localparam int unsigned NumItems = 470;

  typedef logic signed [255:0] wide_t;
  typedef logic [255:0] uwide_t;

  typedef struct {
    logic [3:0]  pos;
    logic [31:0] val;
    bit          drain;
  } load_t;

  typedef struct {
    logic [3:0]  pos;
    logic [31:0] val;
    logic        sing;
    logic        sat;
    logic        last;
  } inv_elem_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready_o;
  logic [3:0]        el_pos = '0;
  logic signed [31:0] el_val = '0;
  logic              out_valid_o;
  logic              out_ready = 1'b0;
  logic [3:0]        result_position_o;
  logic signed [31:0] result_value_o;
  logic              singular_o;
  logic              saturated_o;
  logic              last_result_o;

  load_t       load_q[$];
  inv_elem_t   inverse_q[$];
  logic [31:0] elem_store[16];
  int          n_loaded = 0;
  int          n_errors = 0;
  bit          drain_wait = 0;
  bit          hold_done = 0;
  int          hold_left = 0;
  int          stall_cnt = 0;

  always #4 clk_i = ~clk_i;

  matrix_inverse_4x4_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .element_position_i (el_pos),
    .element_value_i    (el_val),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .result_position_o  (result_position_o),
    .result_value_o     (result_value_o),
    .singular_o         (singular_o),
    .saturated_o        (saturated_o),
    .last_result_o      (last_result_o)
  );

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // signed cofactor of element (r,c) from the 3x3 determinant left after removing row/col
  function automatic wide_t cofactor(input int r, input int c);
    wide_t m[3][3];
    wide_t d;
    int i, j;
    i = 0;
    for (int rr = 0; rr < 4; rr++) begin
      if (rr != r) begin
        j = 0;
        for (int cc = 0; cc < 4; cc++) begin
          if (cc != c) begin
            m[i][j] = wide_t'($signed(elem_store[rr*4+cc]));
            j++;
          end
        end
        i++;
      end
    end
    d = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
      - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
      + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
    return ((r + c) % 2) ? -d : d;
  endfunction

  task automatic load_element(input logic [3:0] pos, input logic [31:0] val);
    wide_t det, adj;
    uwide_t dmag, amag, quo, lim;
    inv_elem_t e;
    bit neg;
    elem_store[pos] = val;
    if (pos != 4'd15) return;
    det = '0;
    for (int c = 0; c < 4; c++) det += wide_t'($signed(elem_store[c])) * cofactor(0, c);
    dmag = det[255] ? uwide_t'(-det) : uwide_t'(det);
    for (int k = 0; k < 16; k++) begin
      e.pos = k[3:0];
      e.val = '0;
      e.sing = (det == 0);
      e.sat = 1'b0;
      e.last = (k == 15);
      if (det != 0) begin
        // inverse element (r,c) is cofactor (c,r) over the determinant
        adj = cofactor(k % 4, k / 4);
        amag = adj[255] ? uwide_t'(-adj) : uwide_t'(adj);
        quo = (amag << (2 * FracBits)) / dmag;
        neg = adj[255] != det[255];
        lim = neg ? uwide_t'(64'h8000_0000) : uwide_t'(64'h7FFF_FFFF);
        if (quo > lim) begin
          e.val = lim[31:0];
          e.sat = 1'b1;
        end else begin
          e.val = neg ? -quo[31:0] : quo[31:0];
        end
      end
      inverse_q.push_back(e);
    end
  endtask

  function automatic bit sender_idle();
    if (n_loaded >= 100 && n_loaded < 300) return 0;
    return $urandom_range(99) < IdlePct;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        load_element(el_pos, el_val);
        n_loaded++;
      end
      if (!in_valid || in_ready_o) begin
        if (drain_wait && inverse_q.size() == 0) drain_wait = 0;
        if (!drain_wait && load_q.size() > 0 && load_q[0].drain) begin
          drain_wait = 1;
          void'(load_q.pop_front());
        end
        if (!drain_wait && load_q.size() > 0 && !sender_idle()) begin
          el_pos <= load_q[0].pos;
          el_val <= load_q[0].val;
          void'(load_q.pop_front());
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (inverse_q.size() == 0) begin
          report($sformatf("unexpected result pos %0d", result_position_o));
        end else begin
          if (result_position_o !== inverse_q[0].pos)
            report($sformatf("position got %0d exp %0d", result_position_o, inverse_q[0].pos));
          if (result_value_o !== inverse_q[0].val)
            report($sformatf("pos %0d value got %h exp %h", inverse_q[0].pos,
                             result_value_o, inverse_q[0].val));
          if (singular_o !== inverse_q[0].sing)
            report($sformatf("pos %0d singular got %b exp %b", inverse_q[0].pos,
                             singular_o, inverse_q[0].sing));
          if (saturated_o !== inverse_q[0].sat)
            report($sformatf("pos %0d saturated got %b exp %b", inverse_q[0].pos,
                             saturated_o, inverse_q[0].sat));
          if (last_result_o !== inverse_q[0].last)
            report($sformatf("pos %0d last got %b exp %b", inverse_q[0].pos,
                             last_result_o, inverse_q[0].last));
          void'(inverse_q.pop_front());
        end
      end
      // one long back-pressure stretch while the sender keeps offering elements
      if (!hold_done && n_loaded >= 130) begin
        hold_done = 1;
        hold_left = RxHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (n_loaded >= 100 && n_loaded < 300) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= $urandom_range(99) >= IdlePct;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_load(input int pos, input logic [31:0] val);
    load_t it;
    it.pos = pos[3:0];
    it.val = val;
    it.drain = 0;
    load_q.push_back(it);
  endtask

  task automatic push_drain();
    load_t it;
    it.pos = '0;
    it.val = '0;
    it.drain = 1;
    load_q.push_back(it);
  endtask

  function automatic logic [31:0] gen_elem(input int kind, input int pos);
    case (kind)
      0: return $urandom;
      1: return ((pos % 5 == 0) ? 32'h0001_0000 : 32'h0) + $urandom_range(32'h3FFFF) - 32'h20000;
      2: return ($urandom_range(8) - 4) << FracBits;
      default: return $urandom_range(8) - 4;
    endcase
  endfunction

  initial begin
    logic [31:0] mat[16];
    int order[15];
    int kind, j, tmp, n_pushed;
    // singular: store still all zero
    push_load(15, 32'h0);
    // tiny diagonal saturates positive, then negative
    push_load(0, 32'h1); push_load(5, 32'h1); push_load(10, 32'h1); push_load(15, 32'h1);
    push_load(15, 32'hFFFF_FFFF);
    // identity in Q16.16
    push_load(0, 32'h1_0000); push_load(5, 32'h1_0000);
    push_load(10, 32'h1_0000); push_load(15, 32'h1_0000);
    // quotient of exactly -2^31 stays unclipped
    push_load(0, 32'hFFFF_FFFE); push_load(15, 32'h1_0000);
    // field extremes
    push_load(1, 32'h8000_0000); push_load(6, 32'h7FFF_FFFF);
    push_load(11, 32'h8000_0000); push_load(12, 32'h7FFF_FFFF);
    push_load(0, 32'h7FFF_FFFF); push_load(15, 32'h8000_0000);
    push_drain();
    n_pushed = 19;
    while (n_pushed < NumItems) begin
      kind = $urandom_range(19);
      if (kind < 2) begin
        push_load($urandom_range(14), $urandom);
        n_pushed++;
      end else if (kind == 2) begin
        push_load(15, gen_elem($urandom_range(3), 15));
        n_pushed++;
      end else begin
        kind = $urandom_range(3);
        for (int p = 0; p < 16; p++) mat[p] = gen_elem(kind, p);
        // rank-deficient now and then: last row copies the first
        if ($urandom_range(5) == 0) for (int c = 0; c < 4; c++) mat[12+c] = mat[c];
        for (int p = 0; p < 15; p++) order[p] = p;
        for (int p = 14; p > 0; p--) begin
          j = $urandom_range(p);
          tmp = order[p]; order[p] = order[j]; order[j] = tmp;
        end
        for (int p = 0; p < 15; p++) push_load(order[p], mat[order[p]]);
        push_load(15, mat[15]);
        n_pushed += 16;
      end
    end
    for (int p = 0; p < 16; p++) elem_store[p] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (load_q.size() > 0 || in_valid || drain_wait || inverse_q.size() > 0);
    repeat (200) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mi4_pkg.sv
rtl/mi4_front.sv
rtl/mi4_queue.sv
rtl/mi4_back.sv
rtl/matrix_inverse_4x4_top.sv
dv/matrix_inverse_4x4_top_tb.sv
